### sv/trr_pkg.sv
// Shared types and constants for the timer resolution rescale block.
// No dependencies; used by timer_resolution_rescale and trr_scale in this folder.
`default_nettype none
package trr_pkg;

  localparam logic [31:0] MAX_RES_DEFAULT = 32'd1000000000;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADARG   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [1:0] RND_TRUNC = 2'd0;
  localparam logic [1:0] RND_HALF  = 2'd1;
  localparam logic [1:0] RND_UP    = 2'd2;

  // widths of the two long dividers
  localparam int DIV1_Q_W = 31;  // rem / res, rem below 2^31
  localparam int DIV2_Q_W = 33;  // scaled remainder, one spare bit flags overflow
  localparam int DEN_W    = 32;

  // item as it enters the first divider
  typedef struct packed {
    logic        bad;
    logic [31:0] secs;
    logic [31:0] rem;
    logic [31:0] res;
    logic [31:0] new_res;
    logic [1:0]  mode;
  } trr_s1_t;

  // item as it enters the second divider
  typedef struct packed {
    logic        bad;
    logic        zero;
    logic [31:0] secs;
    logic [31:0] rem;
    logic [31:0] res;
    logic [31:0] new_res;
    logic [31:0] secs_c;
    logic [30:0] rem_c;
  } trr_s2_t;

endpackage
`default_nettype wire

### sv/timer_resolution_rescale.sv
// Top level of the timer resolution rescale block.
// Depends on trr_pkg, trr_pdiv and trr_scale.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | secs, rem, res, new_res, round_mode
//  out     | out_valid / out_stall| status, secs_out, rem_out, res_out
//
// One transfer per cycle in and out while not stalled. Stages: 32 in the
// carry divider (an input register, then one quotient bit each), one
// multiply stage, 34 in the rescale divider and the output register.
// Synchronous active-low reset clears the valid bits only.
// All stages share one advance enable: a waiting result at the output holds
// the whole pipeline and raises in_stall; no data is dropped or repeated.
`default_nettype none
module timer_resolution_rescale #(
  parameter logic [31:0] MAX_RESOLUTION = trr_pkg::MAX_RES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_secs,
  input  wire logic signed [31:0] in_rem,
  input  wire logic [31:0] in_res,
  input  wire logic [31:0] in_new_res,
  input  wire logic [1:0]  in_round_mode,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_secs_out,
  output logic signed [31:0] out_rem_out,
  output logic [31:0]      out_res_out
);

  localparam int D1_NUM_W = trr_pkg::DEN_W + trr_pkg::DIV1_Q_W;
  localparam int D2_NUM_W = trr_pkg::DEN_W + trr_pkg::DIV2_Q_W;
  localparam int S1_W     = $bits(trr_pkg::trr_s1_t);
  localparam int S2_W     = $bits(trr_pkg::trr_s2_t);

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // argument check up front; bad items still flow, their results are echoes
  trr_pkg::trr_s1_t s1_in;
  always_comb begin
    s1_in.bad     = (in_res == '0) || (in_new_res == '0) ||
                    (in_new_res > MAX_RESOLUTION) || in_rem[31];
    s1_in.secs    = in_secs;
    s1_in.rem     = in_rem;
    s1_in.res     = in_res;
    s1_in.new_res = in_new_res;
    s1_in.mode    = in_round_mode;
  end

  // carry divider: rem / res gives whole seconds and the leftover remainder
  logic                          d1_valid;
  logic [trr_pkg::DIV1_Q_W-1:0]  d1_quot;
  logic [trr_pkg::DEN_W-1:0]     d1_rem;
  logic [S1_W-1:0]               d1_sb;

  trr_pdiv #(
    .D_W (trr_pkg::DEN_W),
    .Q_W (trr_pkg::DIV1_Q_W),
    .SB_W(S1_W)
  ) u_div_carry (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_num   ({{(D1_NUM_W-31){1'b0}}, in_rem[30:0]}),
    .in_den   (in_res),
    .in_sb    (s1_in),
    .out_valid(d1_valid),
    .out_quot (d1_quot),
    .out_rem  (d1_rem),
    .out_sb   (d1_sb)
  );

  logic             sc_valid;
  logic [63:0]      sc_num;
  trr_pkg::trr_s2_t sc_item;

  trr_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (d1_valid),
    .in_item  (trr_pkg::trr_s1_t'(d1_sb)),
    .in_quot  (d1_quot),
    .in_rem   (d1_rem),
    .out_valid(sc_valid),
    .out_num  (sc_num),
    .out_item (sc_item)
  );

  // rescale divider: (rem * new_res + bias) / res; rem < res keeps the
  // quotient within 33 bits, bit 32 is the overflow flag
  logic                         d2_valid;
  logic [trr_pkg::DIV2_Q_W-1:0] d2_quot;
  logic [trr_pkg::DEN_W-1:0]    d2_rem;
  logic [S2_W-1:0]              d2_sb;
  trr_pkg::trr_s2_t             d2_item;

  trr_pdiv #(
    .D_W (trr_pkg::DEN_W),
    .Q_W (trr_pkg::DIV2_Q_W),
    .SB_W(S2_W)
  ) u_div_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sc_valid),
    .in_num   ({{(D2_NUM_W-64){1'b0}}, sc_num}),
    .in_den   (sc_item.res),
    .in_sb    (sc_item),
    .out_valid(d2_valid),
    .out_quot (d2_quot),
    .out_rem  (d2_rem),
    .out_sb   (d2_sb)
  );

  assign d2_item = trr_pkg::trr_s2_t'(d2_sb);

  // result select
  logic [1:0]  status_nxt;
  logic [31:0] secs_nxt;
  logic [31:0] rem_nxt;
  logic [31:0] res_nxt;

  always_comb begin
    if (d2_item.bad) begin
      status_nxt = trr_pkg::ST_BADARG;
      secs_nxt   = d2_item.secs;
      rem_nxt    = d2_item.rem;
      res_nxt    = d2_item.res;
    end else if (d2_item.zero) begin
      status_nxt = trr_pkg::ST_OK;
      secs_nxt   = d2_item.secs_c;
      rem_nxt    = '0;
      res_nxt    = d2_item.new_res;
    end else if (d2_quot[trr_pkg::DIV2_Q_W-1]) begin
      status_nxt = trr_pkg::ST_OVERFLOW;
      secs_nxt   = d2_item.secs_c;
      rem_nxt    = {1'b0, d2_item.rem_c};
      res_nxt    = d2_item.res;
    end else begin
      status_nxt = trr_pkg::ST_OK;
      secs_nxt   = d2_item.secs_c;
      rem_nxt    = d2_quot[31:0];
      res_nxt    = d2_item.new_res;
    end
  end

  // the final remainder of the divider is not part of the result
  logic unused_rem;
  assign unused_rem = ^d2_rem;

  logic        out_valid_r;
  logic [1:0]  status_r;
  logic [31:0] secs_r;
  logic [31:0] rem_r;
  logic [31:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= status_nxt;
      secs_r   <= secs_nxt;
      rem_r    <= rem_nxt;
      res_r    <= unused_rem ? res_nxt : res_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_secs_out = secs_r;
  assign out_rem_out  = rem_r;
  assign out_res_out  = res_r;

  // stall reaches the input exactly when a result is held
  a_stall_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow held result");

  // a good result never exceeds its own resolution
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == trr_pkg::ST_OK) |-> ($unsigned(out_rem_out) <= out_res_out))
    else $error("rescaled remainder above new resolution");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

### sv/trr_pdiv.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing; instantiated twice by timer_resolution_rescale.
`default_nettype none
module trr_pdiv #(
  parameter int D_W  = 32,
  parameter int Q_W  = 33,
  parameter int SB_W = 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [D_W+Q_W-1:0] in_num,   // upper D_W bits must be below in_den
  input  wire logic [D_W-1:0]     in_den,
  input  wire logic [SB_W-1:0]    in_sb,
  output logic                    out_valid,
  output logic [Q_W-1:0]          out_quot,
  output logic [D_W-1:0]          out_rem,
  output logic [SB_W-1:0]         out_sb
);

  logic               v_r   [Q_W+1];
  logic [D_W+Q_W-1:0] w_r   [Q_W+1];
  logic [D_W-1:0]     den_r [Q_W+1];
  logic [SB_W-1:0]    sb_r  [Q_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r[0]   <= in_num;
      den_r[0] <= in_den;
      sb_r[0]  <= in_sb;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [D_W:0]       trial;
    logic [D_W:0]       diff;
    logic               ge;
    logic [D_W-1:0]     r_nxt;
    logic [D_W+Q_W-1:0] w_nxt;

    always_comb begin
      trial = {w_r[k][D_W+Q_W-1:Q_W], w_r[k][Q_W-1]};
      diff  = trial - {1'b0, den_r[k]};
      ge    = (trial >= {1'b0, den_r[k]});
      r_nxt = ge ? diff[D_W-1:0] : trial[D_W-1:0];
      w_nxt = {r_nxt, w_r[k][Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        w_r[k+1]   <= w_nxt;
        den_r[k+1] <= den_r[k];
        sb_r[k+1]  <= sb_r[k];
      end
    end
  end

  assign out_valid = v_r[Q_W];
  assign out_quot  = w_r[Q_W][Q_W-1:0];
  assign out_rem   = w_r[Q_W][D_W+Q_W-1:Q_W];
  assign out_sb    = sb_r[Q_W];

endmodule
`default_nettype wire

### sv/trr_scale.sv
// Carry into seconds, remainder times new resolution, and rounding bias.
// Depends on trr_pkg; sits between the two dividers.
`default_nettype none
module trr_scale (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire trr_pkg::trr_s1_t          in_item,
  input  wire logic [trr_pkg::DIV1_Q_W-1:0] in_quot,
  input  wire logic [trr_pkg::DEN_W-1:0] in_rem,
  output logic                           out_valid,
  output logic [63:0]                    out_num,
  output trr_pkg::trr_s2_t               out_item
);

  logic             valid_r;
  logic [62:0]      prod_r;
  logic [1:0]       mode_r;
  trr_pkg::trr_s2_t item_r;
  logic [31:0]      bias;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // remainder after the carry never exceeds the original, so 31 bits hold it
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r         <= in_rem[30:0] * in_item.new_res;
      mode_r         <= in_item.mode;
      item_r.bad     <= in_item.bad;
      item_r.zero    <= (in_rem == '0);
      item_r.secs    <= in_item.secs;
      item_r.rem     <= in_item.rem;
      item_r.res     <= in_item.res;
      item_r.new_res <= in_item.new_res;
      item_r.secs_c  <= in_item.secs + {1'b0, in_quot};
      item_r.rem_c   <= in_rem[30:0];
    end
  end

  always_comb begin
    case (mode_r)
      trr_pkg::RND_HALF: bias = {1'b0, item_r.res[31:1]};
      trr_pkg::RND_UP:   bias = item_r.res - 32'd1;
      default:           bias = '0;
    endcase
  end

  assign out_valid = valid_r;
  assign out_num   = {1'b0, prod_r} + {32'b0, bias};
  assign out_item  = item_r;

endmodule
`default_nettype wire

### tb/trr_checker.sv
// Scoreboard for timer_resolution_rescale: watches both channels, predicts each
// result from the accepted input and compares. Depends on trr_pkg.
`default_nettype none
module trr_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [31:0] in_secs,
  input  wire logic [31:0] in_rem,
  input  wire logic [31:0] in_res,
  input  wire logic [31:0] in_new_res,
  input  wire logic [1:0]  in_round_mode,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  out_status,
  input  wire logic [31:0] out_secs_out,
  input  wire logic [31:0] out_rem_out,
  input  wire logic [31:0] out_res_out,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] secs;
    logic [31:0] rem;
    logic [31:0] res;
  } rescaled_t;

  rescaled_t rescaled_q[$];

  function automatic rescaled_t rescale_time(logic [31:0] secs, logic [31:0] rem,
                                             logic [31:0] res, logic [31:0] new_res,
                                             logic [1:0] mode);
    rescaled_t r;
    logic [63:0] s, rm, prod, quot;
    s = {32'd0, secs};
    rm = {32'd0, rem};
    if (res == 0 || new_res == 0 || new_res > trr_pkg::MAX_RES_DEFAULT || rem[31]) begin
      r = '{trr_pkg::ST_BADARG, secs, rem, res};
      return r;
    end
    if (rm >= {32'd0, res}) begin
      s = (s + rm / res) & 64'hFFFF_FFFF;
      rm = rm % res;
    end
    if (rm == 0) begin
      r = '{trr_pkg::ST_OK, s[31:0], 32'd0, new_res};
      return r;
    end
    prod = rm * {32'd0, new_res};
    if (mode == trr_pkg::RND_HALF) prod = prod + res / 2;
    else if (mode == trr_pkg::RND_UP) prod = prod + res - 1;
    quot = prod / res;
    if (quot > 64'hFFFF_FFFF) r = '{trr_pkg::ST_OVERFLOW, s[31:0], rm[31:0], res};
    else r = '{trr_pkg::ST_OK, s[31:0], quot[31:0], new_res};
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    rescaled_t want;
    if (!rst_n) begin
      fail_count = 0;
      pending = 0;
    end else begin
      if (in_valid && !in_stall)
        rescaled_q.push_back(rescale_time(in_secs, in_rem, in_res, in_new_res,
                                          in_round_mode));
      if (out_valid && !out_stall) begin
        if (rescaled_q.size() == 0) begin
          report_mismatch("unexpected result", {30'd0, out_status}, 32'd0);
        end else begin
          want = rescaled_q.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", {30'd0, out_status}, {30'd0, want.status});
          if (out_secs_out !== want.secs) report_mismatch("secs", out_secs_out, want.secs);
          if (out_rem_out !== want.rem) report_mismatch("rem", out_rem_out, want.rem);
          if (out_res_out !== want.res) report_mismatch("res", out_res_out, want.res);
        end
      end
      pending = rescaled_q.size();
    end
  end
endmodule
`default_nettype wire

### tb/timer_resolution_rescale_tb.sv
// Testbench top for timer_resolution_rescale: drives directed and random time
// values with random idling, gives the verdict. Depends on trr_pkg, trr_checker.
`default_nettype none
module timer_resolution_rescale_tb;

  localparam int N_RANDOM   = 1930;
  localparam int LATENCY    = 68;
  localparam int CYCLE_CAP  = 200000;
  localparam int CALM_TAIL  = 300;   // last items sent with no idling

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_secs = '0;
  logic [31:0] in_rem = '0;
  logic [31:0] in_res = '0;
  logic [31:0] in_new_res = '0;
  logic [1:0]  in_round_mode = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [1:0]  out_status;
  logic [31:0] out_secs_out, out_rem_out, out_res_out;
  int          fail_count, pending;
  int          cycles = 0;
  bit          calm = 0;       // tail of the run: no idling either side
  bit          hold_off = 0;   // long receiver hold-off in progress

  always #4 clk = ~clk;

  timer_resolution_rescale dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_secs, .in_rem, .in_res, .in_new_res,
    .in_round_mode, .out_valid, .out_stall, .out_status, .out_secs_out,
    .out_rem_out, .out_res_out
  );

  trr_checker scoreboard (
    .clk, .rst_n, .in_valid, .in_stall, .in_secs, .in_rem, .in_res, .in_new_res,
    .in_round_mode, .out_valid, .out_stall, .out_status, .out_secs_out,
    .out_rem_out, .out_res_out, .fail_count, .pending
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[timer_resolution_rescale] ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, none in the calm tail, held solid during
  // the hold-off so the pipe fills and in_stall rises
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= hold_off;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one transfer; payload stays put while stalled
  task automatic send_time(logic [31:0] secs, logic [31:0] rem, logic [31:0] res,
                           logic [31:0] new_res, logic [1:0] mode);
    int gap;
    if (!calm && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_secs <= secs;
    in_rem <= rem;
    in_res <= res;
    in_new_res <= new_res;
    in_round_mode <= mode;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Random resolution, half the time a realistic power of ten, otherwise any value.
  function automatic logic [31:0] pick_res();
    case ($urandom_range(0, 5))
      0: return 32'd1000;
      1: return 32'd1000000;
      2: return trr_pkg::MAX_RES_DEFAULT;
      3: return $urandom_range(1, 100);
      4: return $urandom();
      default: return $urandom_range(1, trr_pkg::MAX_RES_DEFAULT);
    endcase
  endfunction

  initial begin
    logic [31:0] res, new_res, rem;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extremes of every field, each rounding mode, the error cases
    send_time(32'd5, 32'd0, 32'd1000, 32'd1000000, trr_pkg::RND_TRUNC);   // zero rem
    send_time(32'd1, 32'd1, 32'd0, 32'd1000, trr_pkg::RND_TRUNC);         // res zero
    send_time(32'd1, 32'd1, 32'd1000, 32'd0, trr_pkg::RND_TRUNC);         // new_res zero
    send_time(32'd1, 32'd1, 32'd1000, trr_pkg::MAX_RES_DEFAULT + 1,
              trr_pkg::RND_TRUNC);                                        // target too big
    send_time(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd10,
              trr_pkg::RND_UP);                                           // negative rem
    send_time(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd5,
              trr_pkg::RND_HALF);                                         // carry wraps secs
    send_time(32'd0, 32'd2500, 32'd1000, 32'd1000000, trr_pkg::RND_TRUNC); // carry with rest
    send_time(32'd0, 32'd1, 32'd3, 32'd2, trr_pkg::RND_TRUNC);
    send_time(32'd0, 32'd1, 32'd3, 32'd2, trr_pkg::RND_HALF);
    send_time(32'd0, 32'd1, 32'd3, 32'd2, trr_pkg::RND_UP);
    send_time(32'd0, 32'd1, 32'd3, 32'd2, 2'd3);                         // acts as truncate
    send_time(32'd0, 32'd1, 32'd2, 32'd1, trr_pkg::RND_HALF);            // exact half
    send_time(32'd0, 32'h7FFF_FFFE, 32'h7FFF_FFFF, trr_pkg::MAX_RES_DEFAULT,
              trr_pkg::RND_UP);                                           // near-full rem
    send_time(32'd0, 32'd4, 32'd5, 32'd1000000000, trr_pkg::RND_TRUNC);   // large quotient
    send_time(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1, trr_pkg::RND_UP);
    send_time(32'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, trr_pkg::MAX_RES_DEFAULT,
              trr_pkg::RND_HALF);

    // pressure: receiver holds off long while the sender keeps going
    fork
      begin
        hold_off = 1;
        repeat (200) @(negedge clk);
        hold_off = 0;
      end
    join_none

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - CALM_TAIL) calm = 1;
      res = pick_res();
      new_res = pick_res();
      if ($urandom_range(0, 3) == 0) rem = $urandom_range(0, 3) * res + $urandom_range(0, 2);
      else if ($urandom_range(0, 1) == 0 && res != 0) rem = $urandom() % res;
      else rem = $urandom();
      if ($urandom_range(0, 4) != 0) rem[31] = 1'b0; // mostly legal remainders
      if ($urandom_range(0, 30) == 0) new_res = $urandom_range(0, 1) ? 32'd0 : $urandom();
      if ($urandom_range(0, 40) == 0) res = 32'd0;
      send_time($urandom(), rem, res, new_res, 2'($urandom_range(0, 3)));
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("[timer_resolution_rescale] OK");
    else $display("[timer_resolution_rescale] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
